/* rtl/apa_pkg.sv */
// Shared types and constants of the aging priority attention arbiter.
`timescale 1ns / 1ps

package apa_pkg;

   localparam int LEVEL_W  = 16;
   localparam int TIME_W   = 32;
   localparam int CLIENT_W = 2;
   localparam int MARGIN_W = LEVEL_W + 1;
   localparam int CSR_W    = 2;

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_SET      = 2'd1,
      CMD_UPDATE   = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   localparam logic [CSR_W-1:0] CSR_DECAY_RATE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_QUAL_RATE  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_HOLD_MS    = 2'd2;

   // fold request into the running minimum
   typedef struct packed {
      logic                fold;
      logic                clear;
      logic [CLIENT_W-1:0] index;
      logic [LEVEL_W-1:0]  level;
      logic [LEVEL_W-1:0]  quality;
   } fold_ctl_type;

   typedef struct packed {
      logic                found;
      logic [CLIENT_W-1:0] index;
   } fold_status_type;

endpackage

/* rtl/apa_sat_mul.sv */
// Shared saturating multiplier: elapsed time times an unsigned Q16.0 rate, registered.
`timescale 1ns / 1ps

module apa_sat_mul import apa_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [TIME_W-1:0]  elapsed,
   input  logic [LEVEL_W-1:0] rate,
   output logic [LEVEL_W-1:0] product
);

   logic [TIME_W+LEVEL_W-1:0] full_w;
   logic [LEVEL_W-1:0]        product_ff;
   logic [LEVEL_W-1:0]        product_in;

   assign full_w = (TIME_W + LEVEL_W)'(elapsed) * (TIME_W + LEVEL_W)'(rate);

   // saturate at the maximum level when any high bit is set
   assign product_in = (|full_w[TIME_W+LEVEL_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
                                                          : full_w[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* rtl/apa_fold.sv */
// Running minimum of quality minus level over the entries of a round with a nonzero level.
`timescale 1ns / 1ps

module apa_fold import apa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fold_ctl_type    ctl,
   output fold_status_type status
);

   logic                       found_ff;
   logic                       found_in;
   logic [CLIENT_W-1:0]        index_ff;
   logic [CLIENT_W-1:0]        index_in;
   logic signed [MARGIN_W-1:0] margin_ff;
   logic signed [MARGIN_W-1:0] margin_in;
   logic signed [MARGIN_W-1:0] margin_w;

   assign margin_w = $signed({1'b0, ctl.quality}) - $signed({1'b0, ctl.level});

   always_comb begin
      found_in  = found_ff;
      index_in  = index_ff;
      margin_in = margin_ff;
      if (ctl.clear) begin
         found_in  = 1'b0;
         index_in  = '0;
         margin_in = '0;
      end else if (ctl.fold && (ctl.level != '0)) begin
         // strictly smaller only: earlier entry keeps a tie
         if (!found_ff || (margin_w < margin_ff)) begin
            found_in  = 1'b1;
            index_in  = ctl.index;
            margin_in = margin_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         index_ff  <= '0;
         margin_ff <= '0;
      end else begin
         found_ff  <= found_in;
         index_ff  <= index_in;
         margin_ff <= margin_in;
      end
   end

   assign status.found = found_ff;
   assign status.index = index_ff;

endmodule

/* rtl/aging_priority_attention_arbiter.sv */
// Top level of the aging priority attention arbiter: entry table, sequencer, ports.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on the req_ ports, taken at a clock edge with start high and
//   busy low. Every request yields exactly one response, shown for one cycle
//   with rsp_valid high; the receiver cannot stall it.
//   Register, set and no-op requests answer in the cycle after acceptance.
//   An update to an unregistered or out-of-range entry is checked in the age
//   step and then answered. An update to a registered entry runs age, decay
//   multiply, quality multiply, apply, fold and respond. Decay and quality
//   multiply are separate steps because the one shared 32x16 saturating
//   multiplier is used once for the level decay and once for the quality
//   slew.
//   busy stays high from acceptance through the response cycle.
//   rsp_round_done marks an update with end_of_round; winner fields are zero
//   otherwise. The running minimum clears after each report.
//   csr_ writes set the decay rate, quality rate and hold time; csr_ready is
//   always high, writes are expected only while idle. Index 3 is ignored.
//   Synchronous reset empties the table, clears the running minimum and loads
//   the rate and hold defaults; the block is ready on the next cycle.

module aging_priority_attention_arbiter import apa_pkg::*; #(
   parameter int NUM_CLIENTS = 4
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [CLIENT_W-1:0] req_client_index,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic [LEVEL_W-1:0]  req_percent_value,
   input  logic [LEVEL_W-1:0]  req_ref_quality,
   input  logic                req_end_of_round,
   // response channel
   output logic                rsp_valid,
   output logic                rsp_round_done,
   output logic                rsp_winner_found,
   output logic [CLIENT_W-1:0] rsp_winner_index,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [LEVEL_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(NUM_CLIENTS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_AGE   = 6'b000010,
      S_DECAY = 6'b000100,
      S_QUAL  = 6'b001000,
      S_APPLY = 6'b010000,
      S_FOLD  = 6'b100000
   } state_type;

   // response cycle flag: R_SHOW for the one cycle the response is on the ports
   typedef enum logic [1:0] {
      R_OFF  = 2'b01,
      R_SHOW = 2'b10
   } resp_type;

   state_type state_ff, state_in;
   resp_type  resp_ff, resp_in;

   // configuration registers
   logic [LEVEL_W-1:0] decay_rate_ff;
   logic [LEVEL_W-1:0] qual_rate_ff;
   logic [LEVEL_W-1:0] hold_ms_ff;

   // entry table
   logic               entry_valid_ff [NUM_CLIENTS];
   logic [LEVEL_W-1:0] entry_level_ff [NUM_CLIENTS];
   logic [LEVEL_W-1:0] entry_qual_ff  [NUM_CLIENTS];
   logic [TIME_W-1:0]  entry_upd_ff   [NUM_CLIENTS];
   logic [TIME_W-1:0]  entry_req_ff   [NUM_CLIENTS];

   // latched request
   cmd_type             cmd_ff;
   logic [CLIENT_W-1:0] client_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                ok_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [LEVEL_W-1:0]  pct_ff;
   logic [LEVEL_W-1:0]  ref_ff;
   logic                eor_ff;

   // aging working registers
   logic [TIME_W-1:0]  elapsed_ff;
   logic               decay_en_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] qual_ff;

   logic               accept;
   logic               cur_valid;
   logic [LEVEL_W-1:0] cur_level;
   logic [LEVEL_W-1:0] cur_qual;
   logic [TIME_W-1:0]  cur_upd;
   logic [TIME_W-1:0]  cur_req;
   logic [TIME_W-1:0]  since_req;
   logic               mul_en;
   logic [LEVEL_W-1:0] mul_rate;
   logic [LEVEL_W-1:0] step;
   logic [LEVEL_W:0]   qual_sum;
   logic [LEVEL_W-1:0] qual_new;
   logic               close;
   fold_ctl_type       fold_ctl;
   fold_status_type    fold_status;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE) || (resp_ff == R_SHOW);
   assign csr_ready = 1'b1;

   assign cur_valid = entry_valid_ff[idx_ff];
   assign cur_level = entry_level_ff[idx_ff];
   assign cur_qual  = entry_qual_ff[idx_ff];
   assign cur_upd   = entry_upd_ff[idx_ff];
   assign cur_req   = entry_req_ff[idx_ff];
   assign since_req = now_ff - cur_req;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      resp_in  = R_OFF;
      unique case (state_ff)
         S_IDLE: begin
            if (resp_ff == R_OFF && accept) begin
               if (cmd_type'(req_cmd) == CMD_UPDATE) begin
                  state_in = S_AGE;
               end else begin
                  resp_in = R_SHOW;
               end
            end
         end
         S_AGE: begin
            // unregistered or out-of-range entry: nothing to age, answer at once
            if (ok_ff && cur_valid) begin
               state_in = S_DECAY;
            end else begin
               state_in = S_IDLE;
               resp_in  = R_SHOW;
            end
         end
         S_DECAY: state_in = S_QUAL;
         S_QUAL:  state_in = S_APPLY;
         S_APPLY: state_in = S_FOLD;
         S_FOLD: begin
            state_in = S_IDLE;
            resp_in  = R_SHOW;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resp_ff  <= R_OFF;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_rate_ff <= LEVEL_W'(33);
         qual_rate_ff  <= LEVEL_W'(33);
         hold_ms_ff    <= LEVEL_W'(500);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECAY_RATE: decay_rate_ff <= csr_data;
            CSR_QUAL_RATE:  qual_rate_ff  <= csr_data;
            CSR_HOLD_MS:    hold_ms_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         client_ff <= req_client_index;
         idx_ff    <= IDX_W'(req_client_index);
         ok_ff     <= (32'(req_client_index) < NUM_CLIENTS);
         now_ff    <= req_now_ms;
         pct_ff    <= req_percent_value;
         ref_ff    <= req_ref_quality;
         eor_ff    <= req_end_of_round;
      end
   end

   // ---------------------------------------------------------------- shared multiplier
   assign mul_en   = (state_ff == S_DECAY) || (state_ff == S_QUAL);
   assign mul_rate = (state_ff == S_DECAY) ? decay_rate_ff : qual_rate_ff;

   apa_sat_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .elapsed (elapsed_ff),
      .rate    (mul_rate),
      .product (step)
   );

   // quality slew toward the reference; a move in either direction may overshoot it
   assign qual_sum = {1'b0, qual_ff} + {1'b0, step};
   always_comb begin
      if (qual_ff > ref_ff) begin
         qual_new = (step >= qual_ff) ? '0 : qual_ff - step;
      end else if (qual_ff < ref_ff) begin
         qual_new = qual_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : qual_sum[LEVEL_W-1:0];
      end else begin
         qual_new = qual_ff;
      end
   end

   // ---------------------------------------------------------------- aging datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_AGE: begin
            elapsed_ff  <= now_ff - cur_upd;
            decay_en_ff <= since_req > TIME_W'(hold_ms_ff);
            level_ff    <= cur_level;
            qual_ff     <= cur_qual;
         end
         S_QUAL: begin
            // step holds the decay product here
            if (decay_en_ff) begin
               level_ff <= (step >= level_ff) ? '0 : level_ff - step;
            end
         end
         S_APPLY: qual_ff <= qual_new;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- entry table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLIENTS; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (resp_ff == R_SHOW && cmd_ff == CMD_REGISTER && ok_ff) begin
         entry_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FOLD) begin
         entry_level_ff[idx_ff] <= level_ff;
         entry_qual_ff[idx_ff]  <= qual_ff;
         entry_upd_ff[idx_ff]   <= now_ff;
      end else if (resp_ff == R_SHOW && ok_ff) begin
         if (cmd_ff == CMD_REGISTER) begin
            entry_level_ff[idx_ff] <= '0;
            entry_qual_ff[idx_ff]  <= ref_ff;
            entry_upd_ff[idx_ff]   <= now_ff;
            entry_req_ff[idx_ff]   <= now_ff;
         end else if (cmd_ff == CMD_SET && cur_valid && pct_ff >= cur_level) begin
            entry_level_ff[idx_ff] <= pct_ff;
            entry_req_ff[idx_ff]   <= now_ff;
         end
      end
   end

   // ---------------------------------------------------------------- running minimum
   assign close = (resp_ff == R_SHOW) && (cmd_ff == CMD_UPDATE) && eor_ff;

   assign fold_ctl.fold    = (state_ff == S_FOLD);
   assign fold_ctl.clear   = close;
   assign fold_ctl.index   = client_ff;
   assign fold_ctl.level   = level_ff;
   assign fold_ctl.quality = qual_ff;

   apa_fold u_fold (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fold_ctl),
      .status (fold_status)
   );

   // ---------------------------------------------------------------- response
   assign rsp_valid        = (resp_ff == R_SHOW);
   assign rsp_round_done   = close;
   assign rsp_winner_found = close && fold_status.found;
   assign rsp_winner_index = (close && fold_status.found) ? fold_status.index : '0;

   // ---------------------------------------------------------------- checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_resp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after response");

   a_winner_round: assert property (@(posedge clock) disable iff (reset)
      rsp_winner_found |-> (rsp_round_done && rsp_valid))
      else $error("winner reported outside a round close");

   a_fold_no_clear: assert property (@(posedge clock) disable iff (reset)
      fold_ctl.fold |-> !fold_ctl.clear && !rsp_valid)
      else $error("fold overlaps a report");

endmodule
